// ===== hw/rtl/nc5_pkg.sv =====
// ----------------------------------------------------------------------------
// nc5_pkg
// Shared constants for the normalized 5x5 convolution: register map,
// register widths and reset values.
// ----------------------------------------------------------------------------
package nc5_pkg;

    localparam int NUM_KROWS  = 5;
    localparam int KROW_W     = 45;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int PIX_W      = 24;

    localparam logic [KROW_W-1:0] KROW_RESET   = 45'd68853957121;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_KROW0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW4  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd6;

    typedef logic [KROW_W-1:0] t_krow;
    typedef logic [PIX_W-1:0] t_pixel;

endpackage

// ===== hw/rtl/normalized_convolution_5x5.sv =====
// ----------------------------------------------------------------------------
// normalized_convolution_5x5
// Zero-padded, kernel-sum normalized KxK convolution of an RGB raster stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and are written to a single-port-write line
// store; each result then gathers its KxK window from that store one tap per
// cycle, accumulates all three channels in parallel, and divides by the kernel
// sum with a restoring divider, one quotient bit per cycle. An item that
// produces no result returns straight to idle; the divider is skipped when
// the kernel sum is zero. The accumulators and the quotient are SUM_W =
// COEF_BITS + 9 + clog2(KERNEL_SIZE*KERNEL_SIZE) bits wide (23 at defaults).
// The gather is bound by the single memory read port and the divide is
// bit-serial; a stalled receiver holds the result, and no new item is
// accepted until it has been taken. A frame's last results are drained by
// flush items after its final pixel.
// ----------------------------------------------------------------------------
module normalized_convolution_5x5 #(
    parameter int MAX_WIDTH   = 2048,
    parameter int KERNEL_SIZE = 5,
    parameter int COEF_BITS   = 9
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [nc5_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [nc5_pkg::KROW_W-1:0]            i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_kind,
    input  logic [7:0]                            i_in_red,
    input  logic [7:0]                            i_in_green,
    input  logic [7:0]                            i_in_blue,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [7:0]                            o_out_red,
    output logic [7:0]                            o_out_green,
    output logic [7:0]                            o_out_blue,
    output logic                                  o_frame_end
);

    localparam int HALF_K     = KERNEL_SIZE / 2;
    localparam int LINE_DEPTH = 2 * HALF_K * MAX_WIDTH + 2 * HALF_K + 1;
    localparam int AW         = $clog2(LINE_DEPTH);
    localparam int CW         = $clog2(MAX_WIDTH + 1);
    localparam int WW         = (CW > nc5_pkg::WIDTH_W) ? CW : nc5_pkg::WIDTH_W;
    localparam int RW         = nc5_pkg::HEIGHT_W;
    localparam int LW         = CW + RW;
    localparam int KW         = $clog2(KERNEL_SIZE);
    localparam int TAPS       = KERNEL_SIZE * KERNEL_SIZE;
    localparam int SUM_W      = COEF_BITS + 9 + $clog2(TAPS);
    localparam int KS_W       = COEF_BITS + 1 + $clog2(TAPS);
    localparam int DCW        = $clog2(SUM_W + 1);
    localparam int KRI_W      = $clog2(nc5_pkg::NUM_KROWS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TAP   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // configuration
    nc5_pkg::t_krow                r_krow [nc5_pkg::NUM_KROWS];
    logic [nc5_pkg::WIDTH_W-1:0]   r_width;
    logic [nc5_pkg::HEIGHT_W-1:0]  r_height;

    // control
    logic [2:0]       r_state;
    logic [CW-1:0]    r_in_col;
    logic [RW-1:0]    r_in_row;
    logic [CW-1:0]    r_out_col;
    logic [RW-1:0]    r_out_row;
    logic [LW-1:0]    r_cnt_in;
    logic [LW-1:0]    r_cnt_out;
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_optr;
    logic [AW-1:0]    r_rs;
    logic [AW-1:0]    r_a;
    logic [KW-1:0]    r_tm;
    logic [KW-1:0]    r_tn;
    logic             r_p_valid;
    logic [DCW-1:0]   r_dcnt;

    // datapath
    nc5_pkg::t_pixel             mem [LINE_DEPTH];
    nc5_pkg::t_pixel             r_rdata;
    logic                        r_p_mask;
    logic signed [COEF_BITS-1:0] r_p_coef;
    logic signed [SUM_W-1:0]     r_sum [3];
    logic signed [KS_W-1:0]      r_ksum;
    logic [SUM_W-1:0]            r_num [3];
    logic [KS_W-1:0]             r_rem [3];
    logic [KS_W-1:0]             r_den;
    logic                        r_last;

    logic [WW-1:0]   w_raw;
    logic [CW-1:0]   w_eff;
    logic [RW-1:0]   h_eff;
    logic [LW-1:0]   delay;
    logic [AW-1:0]   off0;
    logic [AW:0]     start_ext;
    logic [AW-1:0]   start_addr;
    logic            in_acc;
    logic            in_done;
    logic            is_pix;
    logic            emit;
    logic            mem_we;
    logic [AW-1:0]   a_inc;
    logic [AW:0]     rs_sum;
    logic [AW-1:0]   rs_next;
    logic            row_ok;
    logic            col_ok;
    logic [RW:0]     ty_ext;
    logic [CW:0]     tx_ext;
    logic [nc5_pkg::KROW_W-1:0] krow_sel;
    logic [63:0]     krow_pad;
    logic [63:0]     krow_shift;
    logic            last_pix;
    logic [7:0]      sat [3];

    always_comb begin
        w_raw = WW'(r_width);
        if (w_raw == '0) begin
            w_eff = CW'(1);
        end else if (w_raw > WW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(w_raw);
        end
        h_eff = (r_height == '0) ? RW'(1) : r_height;
    end

    assign delay   = LW'(HALF_K) * LW'(w_eff) + LW'(HALF_K);
    assign off0    = AW'(delay);
    assign in_acc  = i_in_valid && o_in_ready;
    assign in_done = r_in_row >= h_eff;
    assign is_pix  = !i_kind && !in_done;
    assign emit    = is_pix ? (({1'b0, r_cnt_out} + {1'b0, delay}) <= {1'b0, r_cnt_in})
                            : in_done;
    assign mem_we  = in_acc && is_pix;

    always_comb begin
        if (r_optr >= off0) begin
            start_ext = {1'b0, r_optr} - {1'b0, off0};
        end else begin
            start_ext = {1'b0, r_optr} + (AW + 1)'(LINE_DEPTH) - {1'b0, off0};
        end
        start_addr = start_ext[AW-1:0];
        a_inc      = (r_a == AW'(LINE_DEPTH - 1)) ? '0 : r_a + AW'(1);
        rs_sum     = {1'b0, r_rs} + (AW + 1)'(w_eff);
        rs_next    = (rs_sum >= (AW + 1)'(LINE_DEPTH))
                     ? AW'(rs_sum - (AW + 1)'(LINE_DEPTH)) : rs_sum[AW-1:0];
    end

    // tap bounds and coefficient for the tap being read
    always_comb begin
        ty_ext = {1'b0, r_out_row} + (RW + 1)'(r_tm);
        tx_ext = {1'b0, r_out_col} + (CW + 1)'(r_tn);
        row_ok = (ty_ext >= (RW + 1)'(HALF_K)) &&
                 (ty_ext < ({1'b0, h_eff} + (RW + 1)'(HALF_K)));
        col_ok = (tx_ext >= (CW + 1)'(HALF_K)) &&
                 (tx_ext < ({1'b0, w_eff} + (CW + 1)'(HALF_K)));
        if (int'(r_tm) < nc5_pkg::NUM_KROWS) begin
            krow_sel = r_krow[KRI_W'(r_tm)];
        end else begin
            krow_sel = '0;
        end
        krow_pad   = 64'(krow_sel);
        krow_shift = krow_pad >> (int'(r_tn) * COEF_BITS);
    end

    assign last_pix = (({1'b0, r_out_row} + (RW + 1)'(1)) >= {1'b0, h_eff}) &&
                      (({1'b0, r_out_col} + (CW + 1)'(1)) >= {1'b0, w_eff});

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sat[c] = (r_num[c] > SUM_W'(255)) ? 8'hFF : r_num[c][7:0];
        end
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wptr] <= {i_in_blue, i_in_green, i_in_red};
        end
        r_rdata <= mem[r_a];
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < nc5_pkg::NUM_KROWS; r++) begin
                r_krow[r] <= nc5_pkg::KROW_RESET;
            end
            r_width  <= nc5_pkg::WIDTH_RESET;
            r_height <= nc5_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index) inside
                [nc5_pkg::CFG_KROW0:nc5_pkg::CFG_KROW4]: begin
                    if (int'(i_cfg_index) < KERNEL_SIZE) begin
                        r_krow[KRI_W'(i_cfg_index)] <= i_cfg_data;
                    end
                end
                nc5_pkg::CFG_WIDTH: begin
                    r_width <= i_cfg_data[nc5_pkg::WIDTH_W-1:0];
                end
                nc5_pkg::CFG_HEIGHT: begin
                    r_height <= i_cfg_data[nc5_pkg::HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // tap pipeline and accumulation
    always_ff @(posedge i_clk) begin
        r_p_mask <= row_ok && col_ok;
        r_p_coef <= $signed(krow_shift[COEF_BITS-1:0]);
        if (in_acc && emit) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= '0;
            end
            r_ksum <= '0;
        end else if (r_p_valid) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= r_sum[c] + SUM_W'(r_p_coef * $signed({1'b0,
                            (r_p_mask ? r_rdata[c*8 +: 8] : 8'd0)}));
            end
            r_ksum <= r_ksum + KS_W'(r_p_coef);
        end
    end

    // divider lanes
    always_ff @(posedge i_clk) begin
        if (r_state == S_PREP) begin
            for (int c = 0; c < 3; c++) begin
                r_num[c] <= r_sum[c][SUM_W-1] ? SUM_W'(-r_sum[c]) : SUM_W'(r_sum[c]);
                r_rem[c] <= '0;
            end
            r_den <= r_ksum[KS_W-1] ? KS_W'(-r_ksum) : KS_W'(r_ksum);
        end else if (r_state == S_DIV) begin
            for (int c = 0; c < 3; c++) begin
                if ({r_rem[c], r_num[c][SUM_W-1]} >= {1'b0, r_den}) begin
                    r_rem[c] <= KS_W'({r_rem[c], r_num[c][SUM_W-1]} - {1'b0, r_den});
                    r_num[c] <= {r_num[c][SUM_W-2:0], 1'b1};
                end else begin
                    r_rem[c] <= {r_rem[c][KS_W-2:0], r_num[c][SUM_W-1]};
                    r_num[c] <= {r_num[c][SUM_W-2:0], 1'b0};
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN) begin
            o_out_red   <= sat[0];
            o_out_green <= sat[1];
            o_out_blue  <= sat[2];
            o_frame_end <= r_last;
        end
    end

    // sequencer and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_cnt_in  <= '0;
            r_cnt_out <= '0;
            r_wptr    <= '0;
            r_optr    <= '0;
            r_rs      <= '0;
            r_a       <= '0;
            r_tm      <= '0;
            r_tn      <= '0;
            r_p_valid <= 1'b0;
            r_dcnt    <= '0;
            r_last    <= 1'b0;
        end else begin
            r_p_valid <= (r_state == S_TAP);
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (is_pix) begin
                            r_wptr   <= (r_wptr == AW'(LINE_DEPTH - 1)) ? '0
                                                                       : r_wptr + AW'(1);
                            r_cnt_in <= r_cnt_in + LW'(1);
                            if (({1'b0, r_in_col} + (CW + 1)'(1)) >= {1'b0, w_eff}) begin
                                r_in_col <= '0;
                                r_in_row <= r_in_row + RW'(1);
                            end else begin
                                r_in_col <= r_in_col + CW'(1);
                            end
                        end
                        if (emit) begin
                            r_state <= S_TAP;
                            r_tm    <= '0;
                            r_tn    <= '0;
                            r_rs    <= start_addr;
                            r_a     <= start_addr;
                        end
                    end
                end
                S_TAP: begin
                    if (int'(r_tn) == KERNEL_SIZE - 1) begin
                        r_tn <= '0;
                        if (int'(r_tm) == KERNEL_SIZE - 1) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_tm <= r_tm + KW'(1);
                            r_rs <= rs_next;
                            r_a  <= rs_next;
                        end
                    end else begin
                        r_tn <= r_tn + KW'(1);
                        r_a  <= a_inc;
                    end
                end
                S_DRAIN: begin
                    if (!r_p_valid) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_dcnt  <= DCW'(SUM_W);
                    r_state <= (r_ksum == '0) ? S_FIN : S_DIV;
                    r_last  <= last_pix;
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt - DCW'(1);
                    if (r_dcnt == DCW'(1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_OUT;
                    if (r_last) begin
                        r_in_col  <= '0;
                        r_in_row  <= '0;
                        r_out_col <= '0;
                        r_out_row <= '0;
                        r_cnt_in  <= '0;
                        r_cnt_out <= '0;
                        r_wptr    <= '0;
                        r_optr    <= '0;
                    end else begin
                        r_cnt_out <= r_cnt_out + LW'(1);
                        r_optr    <= (r_optr == AW'(LINE_DEPTH - 1)) ? '0
                                                                     : r_optr + AW'(1);
                        if (({1'b0, r_out_col} + (CW + 1)'(1)) >= {1'b0, w_eff}) begin
                            r_out_col <= '0;
                            r_out_row <= r_out_row + RW'(1);
                        end else begin
                            r_out_col <= r_out_col + CW'(1);
                        end
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    a_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input accepted while a result is pending");

    a_pipe_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> (r_state == S_TAP || r_state == S_DRAIN))
        else $error("tap data returned outside window gather");

    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dcnt != '0))
        else $error("divider ran past its last step");

    a_emit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && emit) |=> (r_state == S_TAP && r_tm == '0 && r_tn == '0))
        else $error("emitting item did not start window gather");

endmodule
